// ----- src/bcsm_pkg.sv -----
// Package for the battery charge sequencer: codes, register reset values,
// payload structs and the configuration bundle.
// No dependencies; the design modules and the bench import it.
`timescale 1ns / 1ps

package bcsm_pkg;

    // Field widths fixed by the item format
    localparam int MODE_W   = 2;
    localparam int STATE_W  = 3;
    localparam int CMD_W    = 3;
    localparam int REASON_W = 2;
    localparam int MV_W     = 13;
    localparam int MA_W     = 12;
    localparam int TMR_W    = 32;
    localparam int IVL_W    = 16;
    localparam int DONE_W   = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Done-tick count before topping off
    localparam int DONE_TICKS_DEF = 10;

    // Full-battery test uses the battery voltage plus one twentieth of it
    localparam int VBAT_DIV   = 20;
    localparam int RECIP_SH   = 16;
    localparam int RECIP_MUL  = ((1 << RECIP_SH) + VBAT_DIV - 1) / VBAT_DIV;
    localparam int RECIP_W    = RECIP_SH - 3;

    // Register reset values
    localparam logic [IVL_W-1:0] LOOP_INTERVAL_RST  = IVL_W'(100);
    localparam logic [MA_W-1:0]  COND_CURRENT_RST   = MA_W'(60);
    localparam logic [MV_W-1:0]  CHARGING_MV_RST    = MV_W'(4200);
    localparam logic [MV_W-1:0]  COND_THRESH_MV_RST = MV_W'(2900);
    localparam logic [MV_W-1:0]  COND_MAX_MV_RST    = MV_W'(3000);
    localparam logic [TMR_W-1:0] COND_TIMEOUT_RST   = TMR_W'(3600000);
    localparam logic [TMR_W-1:0] CHG_TIMEOUT_RST    = TMR_W'(14400000);
    localparam logic [TMR_W-1:0] TOPOFF_PERIOD_RST  = TMR_W'(1800000);

    typedef enum logic [STATE_W-1:0] {
        ST_UNINIT   = 3'd0,
        ST_BROKEN   = 3'd1,
        ST_DISABLED = 3'd2,
        ST_WAITING  = 3'd3,
        ST_COND     = 3'd4,
        ST_CHARGING = 3'd5,
        ST_TOPOFF   = 3'd6
    } t_state;

    typedef enum logic [CMD_W-1:0] {
        RC_NONE   = 3'd0,
        RC_STEP   = 3'd1,
        RC_RESET  = 3'd2,
        RC_COND   = 3'd3,
        RC_CHARGE = 3'd4
    } t_ramp_cmd;

    typedef enum logic [REASON_W-1:0] {
        BR_UNINIT     = 2'd0,
        BR_NO_BATTERY = 2'd1,
        BR_TIMEOUT    = 2'd2
    } t_reason;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 2'd0,
        MODE_START   = 2'd1,
        MODE_DISABLE = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_INTERVAL  = 3'd0,
        CFG_COND_CURRENT   = 3'd1,
        CFG_CHARGING_MV    = 3'd2,
        CFG_COND_THRESH_MV = 3'd3,
        CFG_COND_MAX_MV    = 3'd4,
        CFG_COND_TIMEOUT   = 3'd5,
        CFG_CHG_TIMEOUT    = 3'd6,
        CFG_TOPOFF_PERIOD  = 3'd7
    } t_cfg_idx;

    // One tick item
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              supply_present;
        logic [MV_W-1:0]   battery_voltage;
        logic              die_temp_alarm;
        logic              battery_temp_alarm;
        logic [MA_W-1:0]   programmed_current;
        logic [MA_W-1:0]   ramp_target;
        logic              charger_active;
    } t_tick;

    // One result item
    typedef struct packed {
        logic [STATE_W-1:0]  charger_state;
        logic [CMD_W-1:0]    ramp_command;
        logic                set_threshold;
        logic [REASON_W-1:0] broken_reason;
        logic                status_broken;
    } t_result;

    // Configuration bundle from the register file to the sequencer
    typedef struct packed {
        logic [IVL_W-1:0] loop_interval;
        logic [MA_W-1:0]  cond_current;
        logic [MV_W-1:0]  charging_mv;
        logic [MV_W-1:0]  cond_thresh_mv;
        logic [MV_W-1:0]  cond_max_mv;
        logic [TMR_W-1:0] cond_timeout;
        logic [TMR_W-1:0] chg_timeout;
        logic [TMR_W-1:0] topoff_period;
    } t_cfg;

endpackage

// ----- src/bcsm_stream_if.sv -----
// Valid/ready stream interface carrying one payload struct per transfer.
// Payload type is set by the instantiating module (bcsm_pkg structs).
`timescale 1ns / 1ps

interface bcsm_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/battery_charge_state_machine.sv -----
// Top level of the Li-ion charge sequencer: tick input register, sequencer,
// result register and configuration registers.
// Depends on bcsm_pkg, bcsm_stream_if, bcsm_cfg_regs and bcsm_fsm.
//
//   Port       Direction  Carries
//   i_tick     sink       one tick or command (t_tick) per transfer
//   o_res      source     one result (t_result) per accepted item
//   i_cfg_*    write      register index and data, no read-back
//
// Every accepted item passes through the input register and gives one result in the result register.
// One item per cycle is taken while o_res is ready: the input register and the result register
// each free up in the cycle the next stage takes their contents.
// Reset (synchronous, active low) empties both registers and puts the
// sequencer in the uninitialised state with the restart flag set.
// A stalled o_res holds the result; i_tick stalls only when both are full.
`timescale 1ns / 1ps

module battery_charge_state_machine
    import bcsm_pkg::*;
#(
    parameter int DONE_TICKS = DONE_TICKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bcsm_stream_if.sink           i_tick,
    bcsm_stream_if.source         o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_tick   r_in;
    logic    r_in_vld;
    t_result r_out;
    logic    r_out_vld;
    t_result fsm_res;
    logic    fire;
    logic    in_rdy;

    // Item moves into the sequencer when the result register can take it
    assign fire   = r_in_vld && (!r_out_vld || o_res.ready);
    assign in_rdy = !r_in_vld || fire;

    assign i_tick.ready  = in_rdy;
    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    bcsm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bcsm_fsm #(
        .DONE_TICKS (DONE_TICKS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (fsm_res)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_rdy) begin
                r_in_vld <= i_tick.valid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_tick.valid && in_rdy) begin
            r_in <= i_tick.payload;
        end
        if (fire) begin
            r_out <= fsm_res;
        end
    end

endmodule

// ----- src/bcsm_cfg_regs.sv -----
// Configuration register file for the charge sequencer.
// Depends on bcsm_pkg for the index codes, widths and reset values.
`timescale 1ns / 1ps

module bcsm_cfg_regs
    import bcsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes, truncated to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_interval  <= LOOP_INTERVAL_RST;
            r_cfg.cond_current   <= COND_CURRENT_RST;
            r_cfg.charging_mv    <= CHARGING_MV_RST;
            r_cfg.cond_thresh_mv <= COND_THRESH_MV_RST;
            r_cfg.cond_max_mv    <= COND_MAX_MV_RST;
            r_cfg.cond_timeout   <= COND_TIMEOUT_RST;
            r_cfg.chg_timeout    <= CHG_TIMEOUT_RST;
            r_cfg.topoff_period  <= TOPOFF_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOOP_INTERVAL:  r_cfg.loop_interval  <= i_cfg_data[IVL_W-1:0];
                CFG_COND_CURRENT:   r_cfg.cond_current   <= i_cfg_data[MA_W-1:0];
                CFG_CHARGING_MV:    r_cfg.charging_mv    <= i_cfg_data[MV_W-1:0];
                CFG_COND_THRESH_MV: r_cfg.cond_thresh_mv <= i_cfg_data[MV_W-1:0];
                CFG_COND_MAX_MV:    r_cfg.cond_max_mv    <= i_cfg_data[MV_W-1:0];
                CFG_COND_TIMEOUT:   r_cfg.cond_timeout   <= i_cfg_data[TMR_W-1:0];
                CFG_CHG_TIMEOUT:    r_cfg.chg_timeout    <= i_cfg_data[TMR_W-1:0];
                CFG_TOPOFF_PERIOD:  r_cfg.topoff_period  <= i_cfg_data[TMR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/bcsm_fsm.sv -----
// Charge sequencer state, timer, done counter and result logic for one tick.
// Depends on bcsm_pkg; fed from the input register, state commits on i_fire.
`timescale 1ns / 1ps

module bcsm_fsm
    import bcsm_pkg::*;
#(
    parameter int DONE_TICKS = DONE_TICKS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_tick   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam logic [DONE_W-1:0] DONE_LIMIT = DONE_W'(DONE_TICKS);
    localparam logic [RECIP_W-1:0] RECIP_K   = RECIP_W'(RECIP_MUL);

    t_state              r_state, n_state;
    logic [TMR_W-1:0]    r_timer, n_timer;
    logic                r_restart, n_restart;
    logic [DONE_W-1:0]   r_done, n_done;
    t_reason             r_reason, n_reason;
    logic                n_enter;

    logic                alarm;
    logic                active_st;
    logic [TMR_W:0]      tmr_sum;
    logic [TMR_W-1:0]    tmr_adv;
    logic [TMR_W-1:0]    tmr_cur;
    logic [MV_W+RECIP_W-1:0] vbat_prod;
    logic [MV_W:0]       vbat_ext;
    logic                vbat_full;
    logic [DONE_W-1:0]   done_inc;
    logic                done_ok;
    logic                done_hit;
    t_ramp_cmd           cmd;
    logic                thr;
    logic                broke;

    // Shared conditions
    assign alarm     = i_item.die_temp_alarm | i_item.battery_temp_alarm;
    assign active_st = (r_state == ST_COND) || (r_state == ST_CHARGING) ||
                       (r_state == ST_TOPOFF);

    // Saturating timer advance; charging states hold it during an alarm
    assign tmr_sum = {1'b0, r_timer} + (TMR_W+1)'(i_cfg.loop_interval);
    assign tmr_adv = tmr_sum[TMR_W] ? {TMR_W{1'b1}} : tmr_sum[TMR_W-1:0];
    assign tmr_cur = (active_st && alarm) ? r_timer : tmr_adv;

    // Voltage plus a twentieth, by reciprocal multiply (exact for 13 bits)
    assign vbat_prod = (MV_W+RECIP_W)'(i_item.battery_voltage) *
                       (MV_W+RECIP_W)'(RECIP_K);
    assign vbat_ext  = (MV_W+1)'(i_item.battery_voltage) +
                       (MV_W+1)'(vbat_prod[MV_W+RECIP_W-1:RECIP_SH]);
    assign vbat_full = vbat_ext >= (MV_W+1)'(i_cfg.charging_mv);

    // Done test
    assign done_inc = r_done + DONE_W'(1);
    assign done_ok  = (i_item.programmed_current >= i_item.ramp_target) &&
                      !i_item.charger_active;
    assign done_hit = done_ok && (done_inc >= DONE_LIMIT);

    // Next state
    always_comb begin
        n_state   = r_state;
        n_timer   = r_timer;
        n_restart = r_restart;
        n_done    = r_done;
        n_reason  = r_reason;
        n_enter   = 1'b0;
        case (i_item.mode)
            MODE_START: begin
                n_state = ST_WAITING;
                n_enter = 1'b1;
            end
            MODE_DISABLE: begin
                n_state = ST_DISABLED;
                n_enter = 1'b1;
            end
            MODE_TICK: begin
                n_timer = tmr_cur;
                case (r_state)
                    ST_WAITING: begin
                        if (i_item.supply_present && (r_restart || !vbat_full)) begin
                            n_restart = 1'b0;
                            n_enter   = 1'b1;
                            n_state   = (i_item.battery_voltage < i_cfg.cond_thresh_mv) ?
                                        ST_COND : ST_CHARGING;
                        end
                    end
                    ST_COND: begin
                        if (!i_item.supply_present) begin
                            n_state = ST_WAITING;
                            n_enter = 1'b1;
                        end else if (i_item.battery_voltage > i_cfg.cond_max_mv &&
                                     i_item.programmed_current < i_cfg.cond_current) begin
                            n_reason = BR_NO_BATTERY;
                            n_state  = ST_BROKEN;
                            n_enter  = 1'b1;
                        end else if (i_item.battery_voltage >= i_cfg.cond_max_mv) begin
                            n_state = ST_CHARGING;
                            n_enter = 1'b1;
                        end else if (tmr_cur >= i_cfg.cond_timeout) begin
                            n_reason = BR_TIMEOUT;
                            n_state  = ST_BROKEN;
                            n_enter  = 1'b1;
                        end
                    end
                    ST_CHARGING: begin
                        if (!i_item.supply_present) begin
                            n_state = ST_WAITING;
                            n_enter = 1'b1;
                        end else begin
                            n_done = (done_ok && !done_hit) ? done_inc : '0;
                            if (done_hit) begin
                                n_state = ST_TOPOFF;
                                n_enter = 1'b1;
                            end else if (tmr_cur >= i_cfg.chg_timeout) begin
                                n_reason = BR_TIMEOUT;
                                n_state  = ST_BROKEN;
                                n_enter  = 1'b1;
                            end
                        end
                    end
                    ST_TOPOFF: begin
                        if (!i_item.supply_present || tmr_cur >= i_cfg.topoff_period) begin
                            n_state = ST_WAITING;
                            n_enter = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        // Any state entry restarts the timer
        if (n_enter) begin
            n_timer = '0;
        end
    end

    // Result fields
    always_comb begin
        cmd   = RC_NONE;
        thr   = 1'b0;
        broke = 1'b0;
        if (n_enter) begin
            case (n_state)
                ST_COND:     cmd = (i_cfg.cond_current != '0) ? RC_COND : RC_RESET;
                ST_CHARGING: cmd = RC_CHARGE;
                ST_TOPOFF:   cmd = RC_CHARGE;
                default:     cmd = RC_RESET;
            endcase
            thr   = (n_state == ST_CHARGING);
            broke = (n_state == ST_BROKEN);
        end else if (i_item.mode == MODE_TICK && active_st) begin
            cmd = RC_STEP;
        end
        // Charging with supply programs the stop threshold every tick
        if (i_item.mode == MODE_TICK && r_state == ST_CHARGING && i_item.supply_present) begin
            thr = 1'b1;
        end
    end

    assign o_result.charger_state = n_state;
    assign o_result.ramp_command  = cmd;
    assign o_result.set_threshold = thr;
    assign o_result.broken_reason = n_reason;
    assign o_result.status_broken = broke;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_UNINIT;
            r_timer   <= '0;
            r_restart <= 1'b1;
            r_done    <= '0;
            r_reason  <= BR_UNINIT;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_timer   <= n_timer;
            r_restart <= n_restart;
            r_done    <= n_done;
            r_reason  <= n_reason;
        end
    end

`ifndef NO_ASSERTIONS
    // Done counter never holds the limit itself
    a_done_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done < DONE_LIMIT)
        else $error("done counter reached its limit without clearing");

    // A start command lands in waiting with a cleared timer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.mode == MODE_START) |=> (r_state == ST_WAITING && r_timer == '0))
        else $error("start command did not enter waiting");

    // Entering broken always records a reason and clears the timer
    a_broken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && broke) |=> (r_state == ST_BROKEN && r_reason != BR_UNINIT &&
                               r_timer == '0))
        else $error("broken entry without reason or timer clear");

    // Restart flag only ever falls, and only out of waiting
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_restart) |-> $past(r_state) == ST_WAITING)
        else $error("restart flag cleared outside waiting");
`endif

endmodule

// ----- verif/battery_charge_state_machine_tb.sv -----
// Self-checking bench for the Li-ion charge sequencer: directed walk through the states,
// then randomised tick streams under several register settings, with stalls on both sides.
// Depends on bcsm_pkg, bcsm_stream_if and battery_charge_state_machine.
`timescale 1ns / 1ps

module battery_charge_state_machine_tb;
    import bcsm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bcsm_stream_if #(.T_PAYLOAD(t_tick))   tick_if ();
    bcsm_stream_if #(.T_PAYLOAD(t_result)) res_if ();

    battery_charge_state_machine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sequencer copy: registers and state as seen after every accepted transfer
    t_cfg        regs;
    t_state      chg_state;
    logic [31:0] state_ms;
    logic        restart_due;
    logic [3:0]  done_cnt;
    t_reason     fault;
    t_ramp_cmd   step_cmd;
    logic        step_thr;

    t_result results_due[$];
    int      faults = 0;
    int      cycle_count = 0;
    int      hold_left = 0;
    bit      steady = 1'b0;

    // ---------------------------------------------------------------
    // Sequencer prediction
    // ---------------------------------------------------------------
    function automatic void bump_timer();
        logic [32:0] sum;
        sum = state_ms + regs.loop_interval;
        state_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void enter_state(t_state s);
        state_ms = '0;
        case (s)
            ST_COND:     step_cmd = (regs.cond_current != '0) ? RC_COND : RC_RESET;
            ST_CHARGING: begin
                step_cmd = RC_CHARGE;
                step_thr = 1'b1;
            end
            ST_TOPOFF:   step_cmd = RC_CHARGE;
            default:     step_cmd = RC_RESET;
        endcase
        chg_state = s;
    endfunction

    function automatic t_result charger_step(t_tick t);
        t_result r;
        logic    alarm;
        logic    broke;
        logic    topped;
        int      vb;
        alarm    = t.die_temp_alarm | t.battery_temp_alarm;
        vb       = t.battery_voltage;
        broke    = 1'b0;
        topped   = 1'b0;
        step_cmd = RC_NONE;
        step_thr = 1'b0;
        case (t.mode)
            MODE_START:   enter_state(ST_WAITING);
            MODE_DISABLE: enter_state(ST_DISABLED);
            MODE_TICK: begin
                case (chg_state)
                    ST_WAITING: begin
                        bump_timer();
                        // restart always charges; otherwise only a battery below full
                        if (t.supply_present &&
                            (restart_due || vb + vb / VBAT_DIV < regs.charging_mv)) begin
                            restart_due = 1'b0;
                            enter_state(t.battery_voltage < regs.cond_thresh_mv ?
                                        ST_COND : ST_CHARGING);
                        end
                    end
                    ST_COND: begin
                        if (!alarm) bump_timer();
                        if (!t.supply_present) begin
                            enter_state(ST_WAITING);
                        end else if (t.battery_voltage > regs.cond_max_mv &&
                                     t.programmed_current < regs.cond_current) begin
                            fault = BR_NO_BATTERY;
                            enter_state(ST_BROKEN);
                            broke = 1'b1;
                        end else if (t.battery_voltage >= regs.cond_max_mv) begin
                            enter_state(ST_CHARGING);
                        end else if (state_ms >= regs.cond_timeout) begin
                            fault = BR_TIMEOUT;
                            enter_state(ST_BROKEN);
                            broke = 1'b1;
                        end else begin
                            step_cmd = RC_STEP;
                        end
                    end
                    ST_CHARGING: begin
                        if (!alarm) bump_timer();
                        if (!t.supply_present) begin
                            enter_state(ST_WAITING);
                        end else begin
                            step_thr = 1'b1;
                            // done test has to hold for DONE_TICKS ticks in a row
                            if (t.programmed_current >= t.ramp_target && !t.charger_active) begin
                                done_cnt = done_cnt + 4'd1;
                                if (done_cnt >= DONE_TICKS_DEF) begin
                                    done_cnt = '0;
                                    enter_state(ST_TOPOFF);
                                    topped = 1'b1;
                                end
                            end else begin
                                done_cnt = '0;
                            end
                            if (!topped) begin
                                if (state_ms >= regs.chg_timeout) begin
                                    fault = BR_TIMEOUT;
                                    enter_state(ST_BROKEN);
                                    broke = 1'b1;
                                end else begin
                                    step_cmd = RC_STEP;
                                end
                            end
                        end
                    end
                    ST_TOPOFF: begin
                        if (!alarm) bump_timer();
                        if (!t.supply_present || state_ms >= regs.topoff_period)
                            enter_state(ST_WAITING);
                        else
                            step_cmd = RC_STEP;
                    end
                    default: bump_timer();
                endcase
            end
            default: ;
        endcase
        r.charger_state = chg_state;
        r.ramp_command  = step_cmd;
        r.set_threshold = step_thr;
        r.broken_reason = fault;
        r.status_broken = broke;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_tick make_tick(logic [MODE_W-1:0] mode, logic sup, int mv,
                                        logic die_al, logic bat_al, int prog, int tgt,
                                        logic act);
        t_tick t;
        t.mode               = mode;
        t.supply_present     = sup;
        t.battery_voltage    = MV_W'(mv);
        t.die_temp_alarm     = die_al;
        t.battery_temp_alarm = bat_al;
        t.programmed_current = MA_W'(prog);
        t.ramp_target        = MA_W'(tgt);
        t.charger_active     = act;
        return t;
    endfunction

    function automatic t_cfg settings(int loop, int cur, int chg, int thr, int cmax,
                                      logic [31:0] cto, logic [31:0] gto, logic [31:0] top);
        t_cfg c;
        c.loop_interval  = IVL_W'(loop);
        c.cond_current   = MA_W'(cur);
        c.charging_mv    = MV_W'(chg);
        c.cond_thresh_mv = MV_W'(thr);
        c.cond_max_mv    = MV_W'(cmax);
        c.cond_timeout   = cto;
        c.chg_timeout    = gto;
        c.topoff_period  = top;
        return c;
    endfunction

    // Voltage either anywhere in range or close to one of the programmed thresholds
    function automatic int pick_mv();
        int base;
        int v;
        if ($urandom_range(0, 99) < 35) return $urandom_range(0, 8191);
        case ($urandom_range(0, 2))
            0:       base = regs.cond_thresh_mv;
            1:       base = regs.cond_max_mv;
            default: base = (regs.charging_mv * VBAT_DIV) / (VBAT_DIV + 1);
        endcase
        v = base + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 8191) v = 8191;
        return v;
    endfunction

    // Random tick shaped by the predicted state so that charging runs get deep
    function automatic t_tick rand_tick();
        t_tick t;
        int    pick;
        bit    parked;
        bit    busy;
        parked = (chg_state == ST_UNINIT) || (chg_state == ST_BROKEN) ||
                 (chg_state == ST_DISABLED);
        busy   = (chg_state == ST_CHARGING) || (chg_state == ST_TOPOFF);
        pick   = $urandom_range(0, 99);
        t.supply_present     = ($urandom_range(0, 99) < (busy ? 97 : 90));
        t.battery_voltage    = MV_W'(pick_mv());
        t.die_temp_alarm     = ($urandom_range(0, 99) < 8);
        t.battery_temp_alarm = ($urandom_range(0, 99) < 8);
        t.programmed_current = MA_W'($urandom_range(0, 4095));
        t.ramp_target        = MA_W'($urandom_range(0, 4095));
        t.charger_active     = 1'($urandom_range(0, 1));
        if (parked ? pick < 35 : pick < 2)
            t.mode = MODE_START;
        else if (parked ? pick < 40 : pick < 3)
            t.mode = MODE_DISABLE;
        else if (parked ? pick < 43 : pick < 5)
            t.mode = MODE_UNUSED;
        else
            t.mode = MODE_TICK;
        if (chg_state == ST_COND && $urandom_range(0, 99) < 85)
            t.programmed_current = regs.cond_current +
                                   MA_W'($urandom_range(0, 4095 - regs.cond_current));
        if (chg_state == ST_CHARGING && $urandom_range(0, 99) < 90) begin
            t.ramp_target    = MA_W'($urandom_range(0, t.programmed_current));
            t.charger_active = 1'b0;
        end
        return t;
    endfunction

    // One tick transfer, with random idle cycles in front of it unless steady is set
    task automatic send_tick(input t_tick t);
        while (!steady && $urandom_range(0, 99) < 29) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid   <= 1'b1;
        tick_if.payload <= t;
        do @(posedge i_clk); while (!tick_if.ready);
        results_due.push_back(charger_step(t));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_tick(rand_tick());
    endtask

    // Stop offering ticks and wait for every outstanding result
    task automatic settle();
        tick_if.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        settle();
        write_reg(CFG_LOOP_INTERVAL,  CFG_DATA_W'(c.loop_interval));
        write_reg(CFG_COND_CURRENT,   CFG_DATA_W'(c.cond_current));
        write_reg(CFG_CHARGING_MV,    CFG_DATA_W'(c.charging_mv));
        write_reg(CFG_COND_THRESH_MV, CFG_DATA_W'(c.cond_thresh_mv));
        write_reg(CFG_COND_MAX_MV,    CFG_DATA_W'(c.cond_max_mv));
        write_reg(CFG_COND_TIMEOUT,   c.cond_timeout);
        write_reg(CFG_CHG_TIMEOUT,    c.chg_timeout);
        write_reg(CFG_TOPOFF_PERIOD,  c.topoff_period);
        i_cfg_we <= 1'b0;
        regs = c;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset values: idle states, ignored mode, restart, no-battery fault,
    // full-battery hold and the done count into topping off
    task automatic test_directed_walk();
        send_tick(make_tick(MODE_TICK,    1, 8191, 1, 1, 4095, 4095, 1));
        send_tick(make_tick(MODE_UNUSED,  0,    0, 0, 0,    0,    0, 0));
        send_tick(make_tick(MODE_DISABLE, 1, 3000, 0, 0,  100,  100, 0));
        send_tick(make_tick(MODE_TICK,    1, 3000, 0, 0,  100,  100, 0));
        send_tick(make_tick(MODE_START,   0,    0, 0, 0,    0,    0, 0));
        send_tick(make_tick(MODE_TICK,    0, 3500, 0, 0,  500,  100, 0));
        send_tick(make_tick(MODE_TICK,    1,    0, 0, 0,  500,  100, 0));
        send_tick(make_tick(MODE_TICK,    1,  100, 1, 0,   60,    0, 1));
        send_tick(make_tick(MODE_TICK,    1, 8191, 0, 0,    0,    0, 0));
        send_tick(make_tick(MODE_TICK,    1, 3500, 0, 1,  500,  100, 0));
        send_tick(make_tick(MODE_START,   1, 3500, 0, 0,  500,  100, 0));
        send_tick(make_tick(MODE_TICK,    1, 8191, 0, 0,  500,  100, 0));
        send_tick(make_tick(MODE_TICK,    1, 4000, 0, 0,  500,  100, 0));
        send_tick(make_tick(MODE_TICK,    1, 3999, 0, 0,  500,  100, 0));
        repeat (DONE_TICKS_DEF)
            send_tick(make_tick(MODE_TICK, 1, 4100, 0, 0, 4095, 4095, 0));
        send_tick(make_tick(MODE_TICK,    0, 4150, 0, 0, 4095,    0, 0));
    endtask

    // Large interval with short limits so that every timeout is reached
    task automatic test_short_timeouts();
        apply_settings(settings(65535, 60, 4200, 2900, 3000, 200000, 600000, 250000));
        send_random(150);
    endtask

    // Lowest register values but for the full-battery and conditioning thresholds, then a zero full-battery voltage
    task automatic test_low_settings();
        apply_settings(settings(1, 0, 8191, 8191, 0, 0, 0, 0));
        send_random(80);
        apply_settings(settings(1, 0, 0, 0, 0, 0, 0, 0));
        send_random(20);
    endtask

    task automatic test_high_settings();
        apply_settings(settings(65535, 4095, 8191, 8191, 8191,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_random(100);
    endtask

    // Back-to-back transfers on both sides
    task automatic test_steady_stream();
        apply_settings(settings(500, 100, 4200, 2900, 3000, 20000, 60000, 15000));
        steady = 1'b1;
        send_random(150);
        steady = 1'b0;
    endtask

    // Results held off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        hold_left = 200;
        send_random(40);
        settle();
    endtask

    task automatic test_random_settings();
        t_cfg c;
        repeat (3) begin
            c.loop_interval  = IVL_W'($urandom_range(1, 65535));
            c.cond_current   = MA_W'($urandom_range(0, 400));
            c.cond_thresh_mv = MV_W'($urandom_range(1500, 3500));
            c.cond_max_mv    = c.cond_thresh_mv + MV_W'($urandom_range(0, 400));
            c.charging_mv    = MV_W'($urandom_range(3600, 8191));
            c.cond_timeout   = c.loop_interval * $urandom_range(0, 25);
            c.chg_timeout    = c.loop_interval * $urandom_range(0, 40);
            c.topoff_period  = c.loop_interval * $urandom_range(0, 15);
            apply_settings(c);
            send_random(60);
        end
    endtask

    // Short charging run at nearly the largest step with all-ones limits:
    // the timer climbs in big steps while no timeout fires
    task automatic test_timer_saturation();
        int n;
        n = 0;
        apply_settings(settings(65534, 60, 8191, 0, 0,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        steady = 1'b1;
        send_tick(make_tick(MODE_START, 1, 100, 0, 0, 0, 4095, 1));
        send_tick(make_tick(MODE_TICK,  1, 100, 0, 0, 0, 4095, 1));
        while (chg_state == ST_CHARGING && n < 20) begin
            send_tick(make_tick(MODE_TICK, 1, 100, 0, 0, 0, 4095, 1));
            n++;
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls plus the long hold-off
    // ---------------------------------------------------------------
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= steady || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.payload;
            if (results_due.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("%0t: result with none pending: state %0d cmd %0d", $realtime,
                             got.charger_state, got.ramp_command);
            end else begin
                want = results_due.pop_front();
                if (got.charger_state !== want.charger_state ||
                    got.ramp_command  !== want.ramp_command  ||
                    got.set_threshold !== want.set_threshold ||
                    got.broken_reason !== want.broken_reason ||
                    got.status_broken !== want.status_broken) begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("%0t: mismatch exp/got state %0d/%0d cmd %0d/%0d thr %0d/%0d",
                                 $realtime, want.charger_state, got.charger_state,
                                 want.ramp_command, got.ramp_command,
                                 want.set_threshold, got.set_threshold,
                                 "  reason %0d/%0d broken %0d/%0d",
                                 want.broken_reason, got.broken_reason,
                                 want.status_broken, got.status_broken);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence of tests
    // ---------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_LOOP_INTERVAL;
        i_cfg_data      <= '0;
        tick_if.valid   <= 1'b0;
        tick_if.payload <= '0;

        regs        = settings(LOOP_INTERVAL_RST, COND_CURRENT_RST, CHARGING_MV_RST,
                               COND_THRESH_MV_RST, COND_MAX_MV_RST, COND_TIMEOUT_RST,
                               CHG_TIMEOUT_RST, TOPOFF_PERIOD_RST);
        chg_state   = ST_UNINIT;
        state_ms    = '0;
        restart_due = 1'b1;
        done_cnt    = '0;
        fault       = BR_UNINIT;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_walk();
        test_short_timeouts();
        test_low_settings();
        test_high_settings();
        test_steady_stream();
        test_output_backpressure();
        test_random_settings();
        test_timer_saturation();

        settle();
        if (faults == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bcsm_pkg.sv
src/bcsm_stream_if.sv
src/bcsm_cfg_regs.sv
src/bcsm_fsm.sv
src/battery_charge_state_machine.sv
verif/battery_charge_state_machine_tb.sv
